@@ design/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// labeled same-cycle implication, reset gated, reporting through $error
`define FPFLA_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// labeled next-cycle implication, reset gated, reporting through $error
`define FPFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/fpfla_pkg.sv @@
// types and constants of the fixed pool free list allocator
package fpfla_pkg;

    localparam int POOL_SLOTS = 1024;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int LINK_W     = $clog2(POOL_SLOTS + 1);
    localparam int FIELD_W    = 10;
    localparam int CMP_W      = (FIELD_W > LINK_W) ? FIELD_W : LINK_W;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REBUILD = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
    localparam logic [1:0] ST_DOUBLE_FREE = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [FIELD_W-1:0] slot_index;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] granted_slot;
        logic [1:0]         status;
    } t_rsp;

    typedef struct packed {
        logic              mark;
        logic [LINK_W-1:0] link;
    } t_entry;

endpackage

@@ design/fixed_pool_free_list_allocator.sv @@
// fixed pool allocator with a linked free list kept in one slot memory
//
// usage: drive i_req with start high; the beat is taken on an edge where busy
// is low. every command returns exactly one result beat on o_rsp, marked by
// o_done for a single cycle; the receiver cannot stall it.
// allocate and free first read the slot entry from the synchronous slot memory,
// then write it back and register the result, which shows while busy is already
// low; a free that finds the slot already marked free writes nothing back.
// an unused command or an out-of-range free answers the cycle after accept.
// rebuild scans every slot once through the memory read port. an allocate on
// an empty list runs that scan first and then one more read and write, or
// reports exhausted if the scan found no free slot.
// after reset busy stays high while a clearing pass links every slot to the
// next one and marks it free; the list head starts at slot zero. results are
// never dropped: the output register is loaded only on the cycle a command
// finishes.
module fixed_pool_free_list_allocator
    import fpfla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_FREE  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_PICK  = 3'd5;

    t_entry mem [POOL_SLOTS];

    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [LINK_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_after, n_after;
    logic              r_done, n_done;
    t_rsp              r_rsp, n_rsp;
    t_entry            r_rdata;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    t_entry            mem_wdata;
    logic [SLOT_W-1:0] mem_raddr;
    logic              req_in_range;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    assign req_in_range = CMP_W'(i_req.slot_index) < CMP_W'(POOL_SLOTS);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_head    = r_head;
        n_slot    = r_slot;
        n_after   = r_after;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '{mark: 1'b1, link: r_head};
        mem_raddr = r_idx;

        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = '{mark: 1'b1, link: LINK_W'(r_idx) + LINK_W'(1)};
                if (r_idx == LAST_SLOT) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (i_req.command)
                        CMD_ALLOC: begin
                            if (r_head >= NULL_LINK) begin
                                n_after   = 1'b1;
                                n_idx     = '0;
                                n_head    = NULL_LINK;
                                mem_raddr = '0;
                                n_state   = S_SCAN;
                            end else begin
                                mem_raddr = r_head[SLOT_W-1:0];
                                n_state   = S_ALLOC;
                            end
                        end
                        CMD_FREE: begin
                            if (req_in_range) begin
                                n_slot    = SLOT_W'(i_req.slot_index);
                                mem_raddr = SLOT_W'(i_req.slot_index);
                                n_state   = S_FREE;
                            end else begin
                                n_done = 1'b1;
                                n_rsp  = '{granted_slot: '0, status: ST_OK};
                            end
                        end
                        CMD_REBUILD: begin
                            n_after   = 1'b0;
                            n_idx     = '0;
                            n_head    = NULL_LINK;
                            mem_raddr = '0;
                            n_state   = S_SCAN;
                        end
                        default: begin
                            n_done = 1'b1;
                            n_rsp  = '{granted_slot: '0, status: ST_OK};
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                // pop head, keep its link, clear its free mark
                mem_we    = 1'b1;
                mem_waddr = r_head[SLOT_W-1:0];
                mem_wdata = '{mark: 1'b0, link: r_rdata.link};
                n_head    = (r_rdata.link > NULL_LINK) ? NULL_LINK : r_rdata.link;
                n_done    = 1'b1;
                n_rsp     = '{granted_slot: FIELD_W'(r_head), status: ST_OK};
                n_state   = S_IDLE;
            end
            S_FREE: begin
                n_done = 1'b1;
                if (r_rdata.mark) begin
                    n_rsp = '{granted_slot: '0, status: ST_DOUBLE_FREE};
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_slot;
                    mem_wdata = '{mark: 1'b1, link: r_head};
                    n_head    = LINK_W'(r_slot);
                    n_rsp     = '{granted_slot: '0, status: ST_OK};
                end
                n_state = S_IDLE;
            end
            S_SCAN: begin
                // read of the next slot overlaps the write of this one
                if (r_rdata.mark) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = '{mark: 1'b1, link: r_head};
                    n_head    = LINK_W'(r_idx);
                end
                if (r_idx == LAST_SLOT) begin
                    n_idx = '0;
                    if (r_after) begin
                        n_state = S_PICK;
                    end else begin
                        n_done  = 1'b1;
                        n_rsp   = '{granted_slot: '0, status: ST_OK};
                        n_state = S_IDLE;
                    end
                end else begin
                    n_idx     = r_idx + SLOT_W'(1);
                    mem_raddr = r_idx + SLOT_W'(1);
                end
            end
            S_PICK: begin
                // the last scan write has landed, so the head read is safe
                if (r_head >= NULL_LINK) begin
                    n_done  = 1'b1;
                    n_rsp   = '{granted_slot: '0, status: ST_EXHAUSTED};
                    n_state = S_IDLE;
                end else begin
                    mem_raddr = r_head[SLOT_W-1:0];
                    n_state   = S_ALLOC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx   <= '0;
            r_head  <= '0;
            r_after <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_head  <= n_head;
            r_after <= n_after;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_rsp  <= n_rsp;
    end

endmodule

@@ design/fpfla_chk.sv @@
// port-level checker for the allocator, bound to the top level
`include "assert_macros.svh"

module fpfla_chk
    import fpfla_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_req i_req,
    input logic o_done,
    input t_rsp o_rsp
);

    logic req_beat;
    logic free_beat;
    logic rebuild_beat;
    logic free_rsp_ok;
    logic rsp_exhausted;
    logic granted_zero;

    assign req_beat      = start && !busy;
    assign free_beat     = req_beat && i_req.command == CMD_FREE
                           && CMP_W'(i_req.slot_index) < CMP_W'(POOL_SLOTS);
    assign rebuild_beat  = req_beat && i_req.command == CMD_REBUILD;
    assign granted_zero  = o_rsp.granted_slot == '0;
    assign free_rsp_ok   = o_done && granted_zero && o_rsp.status != ST_EXHAUSTED;
    assign rsp_exhausted = o_done && o_rsp.status == ST_EXHAUSTED;

    // an in-range free answers after its slot read and registered result, with a zero slot, never as exhausted
    `FPFLA_ASSERT(a_free_latency, i_clk, i_rst_n, free_beat, ##2 free_rsp_ok, "free result bad")

    // a rebuild always holds off the next beat
    `FPFLA_ASSERT_NEXT(a_rebuild_busy, i_clk, i_rst_n, rebuild_beat, busy, "rebuild not busy")

    // exhaustion is only reported after a scan kept the block busy
    `FPFLA_ASSERT(a_exhaust_after_scan, i_clk, i_rst_n, rsp_exhausted, $past(busy) && granted_zero, "no scan")

endmodule

bind fixed_pool_free_list_allocator fpfla_chk u_fpfla_chk (.*);
